>>> rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds the mode and status codes and the controller/datapath interface structs.
// Depends on nothing; every other file imports it.
package deq_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_DATA_W = 40;

  // Operation requested by an input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_TRAVERSE   = 3'd4
  } mode_e;

  // Status reported with each result item.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    wr_en;       // store the input value
    logic    wr_front;    // 1: push at the front, 0: push at the back
    logic    pop_en;      // remove one element
    logic    pop_front;   // 1: remove at the front, 0: at the back
    logic    idx_clr;     // restart the traverse index
    logic    idx_inc;     // step the traverse index
    logic    out_load;    // load the output register
    status_e out_status;  // status for the loaded result
    logic    out_from_mem;// element comes from the read port, else zero
    logic    out_last;    // last result of this item
  } deq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_last;   // traverse index points at the back element
    logic out_free;   // output register can take a result this cycle
  } deq_sts_t;

endpackage

>>> rtl/deq_ctrl.sv
// Controller state machine of the double-ended queue.
// Decodes input items and sequences traverses; drives the datapath by commands.
// Depends on deq_pkg.
module deq_ctrl
  import deq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [MODE_W-1:0] in_mode_i,
  output logic             in_ready_o,
  input  deq_sts_t         sts_i,
  output deq_cmd_t         cmd_o
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_TRAV_RD  = 2'd1;
  localparam logic [1:0] S_TRAV_OUT = 2'd2;

  logic [1:0] state_q, state_d;
  mode_e      mode;
  logic       accept;

  assign mode       = mode_e'(in_mode_i);
  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_status = STAT_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode) inside
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (sts_i.full) begin
                cmd_o.out_status = STAT_FULL;
              end else begin
                cmd_o.wr_en    = 1'b1;
                cmd_o.wr_front = (mode == MODE_PUSH_FRONT);
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (sts_i.empty) begin
                cmd_o.out_status = STAT_EMPTY;
              end else begin
                cmd_o.pop_en    = 1'b1;
                cmd_o.pop_front = (mode == MODE_POP_FRONT);
              end
            end
            MODE_TRAVERSE: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = STAT_EMPTY;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = S_TRAV_RD;
              end
            end
            default: begin
              // Unused modes are dropped without a result.
            end
          endcase
        end
      end
      S_TRAV_RD: begin
        // Read address is presented; data is registered for the next cycle.
        state_d = S_TRAV_OUT;
      end
      S_TRAV_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_mem = 1'b1;
          cmd_o.out_last     = sts_i.idx_last;
          if (sts_i.idx_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_TRAV_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/deq_dp.sv
// Datapath of the double-ended queue: ring memory, front pointer, count,
// traverse index and the output register. Depends on deq_pkg.
module deq_dp
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [VALUE_W-1:0]    value_i,
  input  deq_cmd_t              cmd_i,
  output deq_sts_t              sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic [VALUE_W-1:0]    out_element_o,
  output logic                  out_last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [DATA_BITS-1:0] rd_data_q;
  logic [DATA_BITS-1:0] wr_data;
  logic [VALUE_W-1:0]   rd_elem;

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [AW-1:0] idx_q, idx_d;

  logic [AW-1:0] front_dec, front_inc;
  logic [AW:0]   back_sum, trav_sum;
  logic [AW-1:0] back_addr, trav_addr, wr_addr;

  logic                out_vld_q, out_vld_d;
  status_e             out_status_q;
  logic [VALUE_W-1:0]  out_elem_q;
  logic                out_last_q;

  // Width conversion between the 32-bit value and the stored word.
  if (DATA_BITS >= VALUE_W) begin : g_wide
    assign wr_data = {{(DATA_BITS - VALUE_W){value_i[VALUE_W-1]}}, value_i};
    assign rd_elem = rd_data_q[VALUE_W-1:0];
  end else begin : g_narrow
    assign wr_data = value_i[DATA_BITS-1:0];
    assign rd_elem = {{(VALUE_W - DATA_BITS){rd_data_q[DATA_BITS-1]}}, rd_data_q};
  end

  // Ring address arithmetic; every sum stays below twice the depth.
  always_comb begin
    front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
    front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
    back_sum  = (AW + 1)'(front_q) + (AW + 1)'(occ_q);
    trav_sum  = (AW + 1)'(front_q) + (AW + 1)'(idx_q);
    back_addr = (back_sum >= (AW + 1)'(DEPTH)) ?
                AW'(back_sum - (AW + 1)'(DEPTH)) : AW'(back_sum);
    trav_addr = (trav_sum >= (AW + 1)'(DEPTH)) ?
                AW'(trav_sum - (AW + 1)'(DEPTH)) : AW'(trav_sum);
    wr_addr   = cmd_i.wr_front ? front_dec : back_addr;
  end

  // Status toward the controller.
  always_comb begin
    sts_o.full     = (occ_q == CW'(DEPTH));
    sts_o.empty    = (occ_q == '0);
    sts_o.idx_last = ((CW'(idx_q) + CW'(1)) == occ_q);
    sts_o.out_free = !out_vld_q || out_ready_i;
  end

  // Pointer, count and index updates.
  always_comb begin
    front_d = front_q;
    occ_d   = occ_q;
    idx_d   = idx_q;
    if (cmd_i.wr_en) begin
      occ_d = occ_q + CW'(1);
      if (cmd_i.wr_front) begin
        front_d = front_dec;
      end
    end else if (cmd_i.pop_en) begin
      occ_d = occ_q - CW'(1);
      // The front only moves when an element remains behind it.
      if (cmd_i.pop_front && (occ_q > CW'(1))) begin
        front_d = front_inc;
      end
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      occ_q   <= '0;
      idx_q   <= '0;
    end else begin
      front_q <= front_d;
      occ_q   <= occ_d;
      idx_q   <= idx_d;
    end
  end

  // Ring memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[trav_addr];
  end

  // Output register; it empties when the consumer takes the item.
  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    if (cmd_i.out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_elem_q   <= cmd_i.out_from_mem ? rd_elem : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_status_o  = out_status_q;
  assign out_element_o = out_elem_q;
  assign out_last_o    = out_last_q;

endmodule

>>> rtl/double_ended_queue.sv
// Double-ended queue over a ring memory. A push or pop item is accepted and its
// status item appears on the output in the next cycle; one per cycle while the
// consumer keeps taking results. A traverse waits on the single registered read
// port of the ring memory for each element; no input is taken meanwhile.
// Reset (rst_ni low, asynchronous) empties the queue and the output register;
// memory contents are not cleared and no clearing pass is run.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [VALUE_W-1:0]    s_axis_tdata_i,  // [31:0] value
  input  logic [MODE_W-1:0]     s_axis_tuser_i,  // [2:0] mode
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // [1:0] status, [33:2] element
  output logic                  m_axis_tlast_o
);

  deq_cmd_t              cmd;
  deq_sts_t              sts;
  logic [STATUS_W-1:0]   out_status;
  logic [VALUE_W-1:0]    out_element;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_mode_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  deq_dp #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (s_axis_tdata_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_status_o  (out_status),
    .out_element_o (out_element),
    .out_last_o    (m_axis_tlast_o)
  );

  // Pack the result fields, zero-filled to whole bytes.
  assign m_axis_tdata_o = {{(OUT_DATA_W - STATUS_W - VALUE_W){1'b0}}, out_element, out_status};

endmodule

>>> rtl/deq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue.
module deq_checker
  import deq_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [VALUE_W-1:0]    s_axis_tdata_i,
  input logic [MODE_W-1:0]     s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tlast_o
);

  logic in_acc;
  logic push_pop;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign push_pop = (s_axis_tuser_i == MODE_PUSH_FRONT) || (s_axis_tuser_i == MODE_PUSH_BACK) ||
                    (s_axis_tuser_i == MODE_POP_FRONT)  || (s_axis_tuser_i == MODE_POP_BACK);

  // A push or pop item gives its single, final status item in the next cycle.
  a_push_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && push_pop |=> m_axis_tvalid_o && m_axis_tlast_o)
    else $error("push or pop item gave no final result in the next cycle");

  // An empty or full status carries no element and ends the item's results.
  a_error_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[STATUS_W-1:0] != STAT_OK) |->
      m_axis_tlast_o && (m_axis_tdata_o[STATUS_W+VALUE_W-1:STATUS_W] == '0))
    else $error("error status with element or without last");

  // Status code three is never produced and the padding bits stay zero.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[STATUS_W-1:0] != 2'd3) &&
      (m_axis_tdata_o[OUT_DATA_W-1:STATUS_W+VALUE_W] == '0))
    else $error("invalid status code or nonzero padding");

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: pushes, pops and traverses on the
// item stream, predicted by a shadow deque and checked result by result.
// Depends on deq_pkg and the double_ended_queue RTL.
module testbench;
  import deq_pkg::*;

  localparam int unsigned RING_DEPTH  = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYC  = 300;

  // One expected result item.
  typedef struct {
    status_e            status;
    logic [VALUE_W-1:0] element;
    logic               last;
  } deq_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_valid = 1'b0;
  logic [VALUE_W-1:0]    s_value = '0;
  logic [MODE_W-1:0]     s_mode = '0;
  logic                  m_ready = 1'b1;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  // Shadow copy of the deque and the results it still owes.
  logic [VALUE_W-1:0] shadow_ring [RING_DEPTH];
  int unsigned        head_slot = 0;
  int unsigned        fill_level = 0;
  deq_result_t        pending_results[$];

  int unsigned mismatches = 0;
  int unsigned full_hits = 0;
  int unsigned empty_hits = 0;
  int unsigned cycle_count = 0;
  int          tx_calm = 0;
  int          rx_calm = 0;
  int          rx_wait = 0;

  double_ended_queue #(
    .DEPTH    (RING_DEPTH),
    .DATA_BITS(32)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_value),
    .s_axis_tuser_i (s_mode),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Clock with a 10 ns period.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycles to idle before the next item; now and then a calm stretch with no idling.
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Applies one accepted item to the shadow deque and queues the results it causes.
  function automatic void predict_results(logic [MODE_W-1:0] op, logic [VALUE_W-1:0] value);
    deq_result_t r;
    int unsigned i;
    r.status  = STAT_OK;
    r.element = '0;
    r.last    = 1'b1;
    case (op) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (fill_level >= RING_DEPTH) begin
          r.status = STAT_FULL;
          full_hits++;
        end else begin
          if (op == MODE_PUSH_FRONT) begin
            head_slot = (head_slot + RING_DEPTH - 1) % RING_DEPTH;
            shadow_ring[head_slot] = value;
          end else begin
            shadow_ring[(head_slot + fill_level) % RING_DEPTH] = value;
          end
          fill_level++;
        end
        pending_results.push_back(r);
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (fill_level == 0) begin
          r.status = STAT_EMPTY;
          empty_hits++;
        end else begin
          // The front slot stays put when the last element leaves.
          if (op == MODE_POP_FRONT && fill_level > 1)
            head_slot = (head_slot + 1) % RING_DEPTH;
          fill_level--;
        end
        pending_results.push_back(r);
      end
      MODE_TRAVERSE: begin
        if (fill_level == 0) begin
          r.status = STAT_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (i = 0; i < fill_level; i++) begin
            r.element = shadow_ring[(head_slot + i) % RING_DEPTH];
            r.last    = (i + 1 == fill_level);
            pending_results.push_back(r);
          end
        end
      end
      default: ;  // Unused modes are dropped without a result.
    endcase
  endfunction

  // Offers one item after a random gap and waits for it to be taken.
  task automatic send_item(logic [MODE_W-1:0] op, logic [VALUE_W-1:0] value);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_value <= value;
    s_mode  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_results(op, value);
  endtask

  // Mostly random values, with the extremes mixed in.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Picks a mode with the given percentages of pushes and pops; the rest are
  // traverses and a few unused modes.
  function automatic logic [MODE_W-1:0] pick_mode(int push_pct, int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    if (roll < push_pct + pop_pct)
      return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
    if (roll < 97)
      return MODE_TRAVERSE;
    return MODE_W'($urandom_range(5, 7));
  endfunction

  // Pops and traverses on the empty queue.
  task automatic test_empty_queue();
    send_item(MODE_TRAVERSE, 32'h1234_5678);
    send_item(MODE_POP_FRONT, 32'hFFFF_FFFF);
    send_item(MODE_POP_BACK, 32'h0000_0000);
  endtask

  // Pushes at both ends with extreme values, then a traverse.
  task automatic test_push_both_ends();
    send_item(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
    send_item(MODE_PUSH_FRONT, 32'h8000_0000);
    send_item(MODE_PUSH_BACK, 32'h0000_0000);
    send_item(MODE_PUSH_BACK, 32'hFFFF_FFFF);
    send_item(MODE_PUSH_BACK, 32'h0000_0001);
    send_item(MODE_TRAVERSE, 32'h0);
  endtask

  // Pops from both ends down to empty, past empty, and a traverse on the way.
  task automatic test_pop_both_ends();
    send_item(MODE_POP_FRONT, 32'h0);
    send_item(MODE_POP_BACK, 32'h0);
    send_item(MODE_TRAVERSE, 32'h0);
    send_item(MODE_POP_FRONT, 32'h0);
    send_item(MODE_POP_BACK, 32'h0);
    send_item(MODE_POP_FRONT, 32'h0);
    send_item(MODE_TRAVERSE, 32'h0);
    send_item(MODE_POP_BACK, 32'h0);
  endtask

  // Unused modes must leave the queue alone and give nothing back.
  task automatic test_unused_modes();
    send_item(3'd5, 32'hA5A5_A5A5);
    send_item(3'd6, 32'h5A5A_5A5A);
    send_item(3'd7, 32'hFFFF_FFFF);
    send_item(MODE_PUSH_BACK, 32'hDEAD_BEEF);
    send_item(3'd7, 32'h0);
    send_item(MODE_TRAVERSE, 32'h0);
    send_item(MODE_POP_FRONT, 32'h0);
  endtask

  // Push-heavy traffic until the full case has been hit several times.
  task automatic test_fill_to_full();
    int n;
    for (n = 0; n < 300 && full_hits < 8; n++)
      send_item(pick_mode(72, 20), pick_value());
  endtask

  // Pop-heavy traffic until the queue has run dry several times.
  task automatic test_drain_to_empty();
    int n;
    for (n = 0; n < 300 && empty_hits < 8; n++)
      send_item(pick_mode(20, 72), pick_value());
  endtask

  // Balanced random traffic.
  task automatic test_mixed_traffic();
    int n;
    for (n = 0; n < 120; n++)
      send_item(pick_mode(46, 44), pick_value());
  endtask

  // Output side: after each result, hold ready low for a random number of cycles.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_ready) begin
      rx_wait = draw_gap(rx_calm);
      if (rx_wait > 0)
        m_ready <= 1'b0;
    end else if (!m_ready) begin
      rx_wait--;
      if (rx_wait <= 0)
        m_ready <= 1'b1;
    end
  end

  // Compares each result item against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    deq_result_t want;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: tdata=%h tlast=%b", m_axis_tdata_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata_o[1:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[33:2] !== want.element) begin
          $error("element: expected %h, got %h", want.element, m_axis_tdata_o[33:2]);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_push_both_ends();
    test_pop_both_ends();
    test_unused_modes();
    test_fill_to_full();
    test_drain_to_empty();
    test_fill_to_full();
    test_mixed_traffic();

    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> double_ended_queue.f
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
tb/testbench.sv
